// File: rtl/core/firsr_pkg.sv
// Shared types, constants and a helper function for the shift-register FIR filter.
`default_nettype none

package firsr_pkg;

    // Word width of samples, coefficients, products and the running sum.
    localparam int DATA_W = 32;

    // Width of the coefficient index field.
    localparam int IDX_W = 4;

    // Default number of taps.
    localparam int TAPS_DEFAULT = 11;

    // Item operation codes.
    typedef enum logic [0:0] {
        OP_FILTER      = 1'b0,
        OP_COEFF_WRITE = 1'b1
    } op_t;

    // One input beat.
    typedef struct packed {
        op_t                       operation;
        logic signed [DATA_W-1:0]  sample;
        logic        [IDX_W-1:0]   coeff_index;
        logic signed [DATA_W-1:0]  coeff_value;
        logic                      block_end;
    } item_t;

    // One output beat.
    typedef struct packed {
        logic signed [DATA_W-1:0]  filtered;
        logic                      last_of_block;
    } result_t;

    // Sideband that travels alongside a sample through the adder tree.
    typedef struct packed {
        logic valid;
        logic last;
    } ctl_t;

    // Depth of the registered adder tree; a single leaf still gets one level.
    function automatic int tree_levels(input int leaves);
        int levels;
        levels = (leaves > 1) ? $clog2(leaves) : 1;
        return levels;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/firsr_tap_cell.sv
// One tap of the filter: delay register, coefficient register and a registered product.
`default_nettype none

module firsr_tap_cell (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              shift_en,
    input  wire logic                              clear,
    input  wire logic                              coeff_we,
    input  wire logic [firsr_pkg::DATA_W-1:0]      coeff_value,
    input  wire logic [firsr_pkg::DATA_W-1:0]      tap_in,
    output logic      [firsr_pkg::DATA_W-1:0]      tap_out,
    output logic      [firsr_pkg::DATA_W-1:0]      product
);

    logic [firsr_pkg::DATA_W-1:0] delay_reg;
    logic [firsr_pkg::DATA_W-1:0] delay_next;
    logic [firsr_pkg::DATA_W-1:0] weight_reg;
    logic [firsr_pkg::DATA_W-1:0] product_reg;
    logic [firsr_pkg::DATA_W-1:0] product_next;

    // The end of a block empties the delay line after this sample has been used.
    always_comb
    begin
        delay_next   = clear ? '0 : tap_in;
        product_next = firsr_pkg::DATA_W'(tap_in * weight_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg  <= '0;
            weight_reg <= '0;
        end
        else
        begin
            if (shift_en)
            begin
                delay_reg <= delay_next;
            end
            if (coeff_we)
            begin
                weight_reg <= coeff_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            product_reg <= product_next;
        end
    end

    assign tap_out = delay_reg;
    assign product = product_reg;

endmodule

`default_nettype wire

// File: rtl/core/firsr_add_tree.sv
// Registered binary adder tree that sums the tap products, with its sideband pipeline.
`default_nettype none

module firsr_add_tree #(
    parameter int LEAVES = firsr_pkg::TAPS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire firsr_pkg::ctl_t                   ctl_in,
    input  wire logic [firsr_pkg::DATA_W-1:0]      leaf [LEAVES],
    output firsr_pkg::ctl_t                        ctl_out,
    output logic      [firsr_pkg::DATA_W-1:0]      sum
);

    localparam int LEVELS = firsr_pkg::tree_levels(LEAVES);
    localparam int SPAN   = 1 << LEVELS;
    localparam int INNER  = SPAN - 1;

    logic [firsr_pkg::DATA_W-1:0] pad      [SPAN];
    logic [firsr_pkg::DATA_W-1:0] node_reg [INNER];
    firsr_pkg::ctl_t              ctl_reg  [LEVELS+1];

    // Missing leaves contribute zero.
    for (genvar j = 0; j < SPAN; j++)
    begin : g_pad
        if (j < LEAVES)
        begin : g_used
            assign pad[j] = leaf[j];
        end
        else
        begin : g_zero
            assign pad[j] = '0;
        end
    end

    // Heap layout: node i has children 2i+1 and 2i+2; indices from INNER on are leaves.
    for (genvar i = 0; i < INNER; i++)
    begin : g_node
        logic [firsr_pkg::DATA_W-1:0] node_next;

        if (2 * i + 1 >= INNER)
        begin : g_from_leaf
            assign node_next = pad[2*i+1-INNER] + pad[2*i+2-INNER];
        end
        else
        begin : g_from_node
            assign node_next = node_reg[2*i+1] + node_reg[2*i+2];
        end

        always_ff @(posedge clk)
        begin
            node_reg[i] <= node_next;
        end
    end

    // The sideband is registered together with the tap products, then again at each tree level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= LEVELS; s++)
            begin
                ctl_reg[s] <= '0;
            end
        end
        else
        begin
            ctl_reg[0] <= ctl_in;
            for (int s = 1; s <= LEVELS; s++)
            begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
        end
    end

    assign ctl_out = ctl_reg[LEVELS];
    assign sum     = node_reg[0];

endmodule

`default_nettype wire

// File: rtl/core/firsr_result_fifo.sv
// Small result queue between the adder tree and the output channel.
`default_nettype none

module firsr_result_fifo #(
    parameter int DEPTH = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire firsr_pkg::result_t   push_data,
    input  wire logic                 pop,
    output logic                      valid,
    output firsr_pkg::result_t        data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    firsr_pkg::result_t   entry_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign valid = (count_reg != '0);
    assign data  = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// File: rtl/core/fir_filter_shift_register.sv
// Top level of the direct-form FIR filter built from a chain of tap cells.
//
//   Channel  Direction  Handshake                    Beat contents
//   item     in         item_valid / item_stall      firsr_pkg::item_t (sample or coefficient)
//   result   out        result_valid / result_stall  firsr_pkg::result_t (one per sample)
//
// One beat is taken every clock while there is room; a coefficient write gives no result.
// A sample's result passes the product registers, the L levels of the registered adder
// tree, where L = ceil(log2(TAPS)) (at least 1), and the result queue before it leaves.
// Reset clears the delay line and every coefficient to zero and empties the result queue.
// Input is stalled only when the results in flight and queued fill the queue, which has
// room for L + 3 results, so a stall at the output holds the input back a few beats later.
`default_nettype none

module fir_filter_shift_register #(
    parameter int TAPS = firsr_pkg::TAPS_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire firsr_pkg::item_t      item,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output firsr_pkg::result_t         result
);

    // Depth of the registered adder tree behind the product registers, and queue size to match.
    localparam int LEVELS = firsr_pkg::tree_levels(TAPS);
    localparam int CAP    = LEVELS + 3;
    localparam int OCC_W  = $clog2(CAP + 1);

    logic                          item_accept;
    logic                          sample_accept;
    logic                          coeff_accept;
    logic                          result_accept;

    logic [OCC_W-1:0]              occ_reg;
    logic [OCC_W-1:0]              occ_next;

    // window[k] is the sample k steps back as seen by this beat; window[0] is the new one.
    logic [firsr_pkg::DATA_W-1:0]  window  [TAPS+1];
    logic [firsr_pkg::DATA_W-1:0]  product [TAPS];

    firsr_pkg::ctl_t               tree_ctl_in;
    firsr_pkg::ctl_t               tree_ctl_out;
    logic [firsr_pkg::DATA_W-1:0]  tree_sum;
    firsr_pkg::result_t            tree_result;

    assign item_accept   = item_valid && !item_stall;
    assign sample_accept = item_accept && (item.operation == firsr_pkg::OP_FILTER);
    assign coeff_accept  = item_accept && (item.operation == firsr_pkg::OP_COEFF_WRITE);
    assign result_accept = result_valid && !result_stall;

    // Occupancy counts samples taken whose results have not yet left; it acts as a
    // credit so that the queue at the end of the tree can never overflow.
    always_comb
    begin
        occ_next = occ_reg;
        if (sample_accept && !result_accept)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (result_accept && !sample_accept)
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    assign item_stall = (occ_reg == OCC_W'(CAP));

    assign window[0] = item.sample;

    // Each cell multiplies its window word by its coefficient and, on a sample, hands
    // that word on to its neighbour, so the chain itself is the delay line. Indices that
    // do not name a tap select no cell, which makes such writes vanish.
    for (genvar k = 0; k < TAPS; k++)
    begin : g_cell
        logic coeff_we;

        assign coeff_we = coeff_accept && (int'(item.coeff_index) == k);

        firsr_tap_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .shift_en    (sample_accept),
            .clear       (item.block_end),
            .coeff_we    (coeff_we),
            .coeff_value (item.coeff_value),
            .tap_in      (window[k]),
            .tap_out     (window[k+1]),
            .product     (product[k])
        );
    end

    assign tree_ctl_in.valid = sample_accept;
    assign tree_ctl_in.last  = item.block_end;

    firsr_add_tree #(
        .LEAVES (TAPS)
    ) u_tree (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (tree_ctl_in),
        .leaf    (product),
        .ctl_out (tree_ctl_out),
        .sum     (tree_sum)
    );

    assign tree_result.filtered      = tree_sum;
    assign tree_result.last_of_block = tree_ctl_out.last;

    firsr_result_fifo #(
        .DEPTH (CAP)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (tree_ctl_out.valid),
        .push_data (tree_result),
        .pop       (result_accept),
        .valid     (result_valid),
        .data      (result)
    );

endmodule

`default_nettype wire

// File: dv/fir_filter_shift_register_test.sv
// Self-checking testbench for the shift-register FIR filter, predicting every filtered beat.
`timescale 1ns / 100ps

module fir_filter_shift_register_test;

    // The block is built with its default tap count, so the predictor uses the same one.
    localparam int TAPS = firsr_pkg::TAPS_DEFAULT;

    // The clock period is 8 ns, so each half period is 4 ns.
    localparam real HALF_PERIOD = 4.0;
    localparam int RESET_CYCLES = 12;

    // Roughly how many random beats follow the directed opening.
    localparam int RANDOM_ITEMS = 1350;

    // A sample passes the product registers, the adder tree and the result queue on its way out.
    // The settling time after the last result is several times that passage.
    localparam int DRAIN_CYCLES = 64;

    // The slowest legal run has about 1400 beats. At worst each one waits out a long
    // input gap, a long output stall and the pipeline. The CYCLE_LIMIT below covers that
    // several times over.
    localparam int CYCLE_LIMIT = 1_000_000;

    // Only the first few mismatches are printed in full. Later ones are counted.
    localparam int REPORT_LIMIT = 10;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    logic               item_stall;
    firsr_pkg::item_t   item         = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    firsr_pkg::result_t result;

    fir_filter_shift_register #(
        .TAPS (TAPS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // The predictor keeps its own copy of the coefficient store and the delay line.
    // Only TAPS-1 entries of the history are used. The extra entry keeps the
    // declaration legal for a single tap.
    logic [firsr_pkg::DATA_W-1:0] tap_coeff [TAPS];
    logic [firsr_pkg::DATA_W-1:0] history   [TAPS];

    // expected_sums holds the predicted results, oldest first.
    firsr_pkg::result_t expected_sums [$];

    // item_backlog holds the beats that are still waiting to be offered to the block.
    firsr_pkg::item_t   item_backlog  [$];

    int mismatch_count = 0;
    int cycle_count    = 0;

    // The monitor sets this flag at every rising edge to show whether the item beat on
    // the bus was taken. The driver reads it at the following falling edge.
    bit beat_taken = 1'b0;

    int gap_left   = 0;
    int stall_left = 0;
    int flow_left  = 0;

    // Prints a mismatch in full while few have been seen. After that it only counts.
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    // Works out the effect of one accepted item beat on the filter.
    // A coefficient write only updates the store. A sample produces one expected result.
    // The products and the running sum are kept at 32 bits, so they wrap exactly as
    // the hardware does.
    function automatic void fir_predict(input firsr_pkg::item_t beat);
        logic [firsr_pkg::DATA_W-1:0] acc;
        firsr_pkg::result_t           res;
        if (beat.operation == firsr_pkg::OP_COEFF_WRITE)
        begin
            // A write to a tap that does not exist is dropped. Its block_end flag is
            // ignored as well.
            if (beat.coeff_index < TAPS)
            begin
                tap_coeff[beat.coeff_index] = beat.coeff_value;
            end
        end
        else
        begin
            acc = beat.sample * tap_coeff[0];
            for (int k = 1; k < TAPS; k++)
            begin
                acc = acc + history[k-1] * tap_coeff[k];
            end
            for (int k = TAPS - 2; k >= 1; k--)
            begin
                history[k] = history[k-1];
            end
            if (TAPS > 1)
            begin
                history[0] = beat.sample;
            end
            // The end of a block returns the delay line to rest. The next block therefore
            // sees only its own samples.
            if (beat.block_end)
            begin
                for (int k = 0; k < TAPS; k++)
                begin
                    history[k] = '0;
                end
            end
            res.filtered      = acc;
            res.last_of_block = beat.block_end;
            expected_sums.push_back(res);
        end
    endfunction

    // Picks a data word. The extremes turn up often, because they are where the
    // wrap-around shows.
    function automatic logic [firsr_pkg::DATA_W-1:0] rand_word();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            4:       return $urandom_range(0, 511) - 256;
            default: return $urandom;
        endcase
    endfunction

    // Builds a sample beat. The coefficient fields carry rubbish, which the block must
    // ignore.
    function automatic firsr_pkg::item_t make_sample(
        input logic [firsr_pkg::DATA_W-1:0] x,
        input logic                         last);
        firsr_pkg::item_t beat;
        beat.operation   = firsr_pkg::OP_FILTER;
        beat.sample      = x;
        beat.coeff_index = firsr_pkg::IDX_W'($urandom_range(0, 15));
        beat.coeff_value = $urandom;
        beat.block_end   = last;
        return beat;
    endfunction

    // Builds a coefficient write. The sample field carries rubbish, which the block must
    // ignore.
    function automatic firsr_pkg::item_t make_write(
        input logic [firsr_pkg::IDX_W-1:0]  idx,
        input logic [firsr_pkg::DATA_W-1:0] val,
        input logic                         last);
        firsr_pkg::item_t beat;
        beat.operation   = firsr_pkg::OP_COEFF_WRITE;
        beat.sample      = $urandom;
        beat.coeff_index = idx;
        beat.coeff_value = val;
        beat.block_end   = last;
        return beat;
    endfunction

    // Picks an idle length. Most idle periods are zero or short, and a few are long.
    // Whenever bits 10 and 9 of cycle_count are both set, no idling is picked on either side,
    // so the block also runs at full rate.
    function automatic int pick_gap();
        int unsigned roll;
        if (cycle_count[10:9] == 2'b11)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        else if (roll < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (roll < 97)
        begin
            return $urandom_range(4, 10);
        end
        else
        begin
            return $urandom_range(20, 60);
        end
    endfunction

    // Stimulus and end of test.
    initial
    begin
        int               seq_len;
        int               writes;
        firsr_pkg::item_t noise;

        for (int k = 0; k < TAPS; k++)
        begin
            tap_coeff[k] = '0;
            history[k]   = '0;
        end

        // Directed opening. The coefficients are still zero after reset, so even the
        // largest sample must give zero.
        item_backlog.push_back(make_sample(32'h7FFF_FFFF, 1'b0));
        // Write the extreme values to the first and the last tap.
        item_backlog.push_back(make_write(4'd0, 32'h7FFF_FFFF, 1'b0));
        item_backlog.push_back(make_write(4'd10, 32'h8000_0000, 1'b0));
        // These taps do not exist, so both writes must leave the store untouched.
        item_backlog.push_back(make_write(4'd11, 32'h1234_5678, 1'b0));
        item_backlog.push_back(make_write(4'd15, 32'hFFFF_FFFF, 1'b1));
        // The block_end flag on a write must not clear the delay line or give a result.
        item_backlog.push_back(make_write(4'd5, 32'hFFFF_FFFF, 1'b1));
        // This block is long enough for the first sample to reach the last tap.
        // The samples at the extremes then meet coefficients at the extremes, and the
        // products overflow.
        item_backlog.push_back(make_sample(32'h8000_0000, 1'b0));
        item_backlog.push_back(make_sample(32'h7FFF_FFFF, 1'b0));
        item_backlog.push_back(make_sample(32'hFFFF_FFFF, 1'b0));
        item_backlog.push_back(make_sample(32'h0000_0000, 1'b0));
        item_backlog.push_back(make_sample(32'h0000_0001, 1'b0));
        for (int n = 0; n < 6; n++)
        begin
            item_backlog.push_back(make_sample(rand_word(), 1'b0));
        end
        item_backlog.push_back(make_sample(32'h8000_0000, 1'b1));
        // After the block end only the current sample may contribute.
        item_backlog.push_back(make_sample(32'h7FFF_FFFF, 1'b1));

        // The random part is mostly well-formed blocks. Each block has a few coefficient
        // writes followed by a run of samples, and its last sample carries block_end.
        // Bursts of fully random beats are mixed in as noise.
        while (item_backlog.size() < RANDOM_ITEMS + 20)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                writes = $urandom_range(0, 3);
                repeat (writes)
                begin
                    item_backlog.push_back(make_write(
                        firsr_pkg::IDX_W'(($urandom_range(0, 9) == 0)
                                          ? $urandom_range(11, 15)
                                          : $urandom_range(0, 10)),
                        rand_word(), 1'($urandom_range(0, 1))));
                end
                seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40)
                                                      : $urandom_range(1, 12);
                for (int n = 1; n <= seq_len; n++)
                begin
                    item_backlog.push_back(make_sample(rand_word(), n == seq_len));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    noise.operation   = firsr_pkg::op_t'($urandom_range(0, 1));
                    noise.sample      = $urandom;
                    noise.coeff_index = firsr_pkg::IDX_W'($urandom_range(0, 15));
                    noise.coeff_value = $urandom;
                    noise.block_end   = 1'($urandom_range(0, 1));
                    item_backlog.push_back(noise);
                end
            end
        end

        // Release reset on a falling edge. The nonblocking assignment means the driver
        // still sees reset at that edge and starts at the next one.
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait until every beat has gone in and every predicted result has come out.
        while (item_backlog.size() != 0 || item_valid || expected_sums.size() != 0)
        begin
            @(posedge clk);
        end

        // Give any stray result time to appear, so that the monitor can flag it.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_sums.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_sums.size()));
        end

        if (mismatch_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Item driver. A new beat is presented only once the current one has been taken or
    // none is on the bus. A stalled beat therefore holds its payload unchanged.
    // Each pass makes a single nonblocking update of valid, so a run of back-to-back
    // beats keeps valid high.
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || beat_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                item_valid <= 1'b0;
            end
            else if (item_backlog.size() != 0)
            begin
                item       <= item_backlog.pop_front();
                item_valid <= 1'b1;
                gap_left    = pick_gap();
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Result-side back pressure. Stretches of stall alternate with stretches of flow,
    // and both have random lengths.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (flow_left > 0)
            begin
                flow_left--;
                result_stall <= 1'b0;
            end
            else
            begin
                stall_left = pick_gap();
                flow_left  = $urandom_range(0, 12);
                result_stall <= (stall_left > 0);
                if (stall_left > 0)
                begin
                    stall_left--;
                end
            end
        end
    end

    // Monitor. It samples both channels at the rising edge, before the block updates
    // its outputs. Each accepted item beat goes through the predictor. Each accepted
    // result beat is checked against the oldest prediction.
    always @(posedge clk)
    begin
        firsr_pkg::result_t want;
        beat_taken = rst_n && item_valid && !item_stall;
        if (beat_taken)
        begin
            fir_predict(item);
        end
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_sums.size() == 0)
            begin
                report_mismatch($sformatf("result beat with nothing expected: filtered %h last %b",
                                          result.filtered, result.last_of_block));
            end
            else
            begin
                want = expected_sums.pop_front();
                if (result.filtered !== want.filtered)
                begin
                    report_mismatch($sformatf("filtered: expected %h, got %h",
                                              want.filtered, result.filtered));
                end
                if (result.last_of_block !== want.last_of_block)
                begin
                    report_mismatch($sformatf("last_of_block: expected %b, got %b",
                                              want.last_of_block, result.last_of_block));
                end
            end
        end
    end

    // Watchdog. A run that hangs ends here as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
